@@ design/nnt_pkg.sv @@
// ----------------------------------------------------------------------------
// nnt_pkg: shared types and constants for the nearest-neighbor tour builder
// Cell count, field widths, the candidate token that moves down the cell
// row and the control bus that the sequencer broadcasts to every cell.
// ----------------------------------------------------------------------------
`default_nettype none

package nnt_pkg;

  // Number of point cells; bounded by the 5-bit point index.
  localparam int NUM_CELLS = 32;
  localparam int IDX_W     = $clog2(NUM_CELLS);
  localparam int CNT_W     = IDX_W + 1;
  localparam int COORD_W   = 16;
  localparam int DIST_W    = COORD_W + 1;

  // Last scan timer value: the scan covers the distance register and the ripple through every cell.
  localparam logic [CNT_W-1:0] SCAN_LAST = CNT_W'(NUM_CELLS);

  // Best-so-far candidate, passed from cell to cell.
  typedef struct packed {
    logic                      vld;
    logic [DIST_W-1:0]         mdist;
    logic [IDX_W-1:0]          idx;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } cand_t;

  // Broadcast from the sequencer to all cells.
  typedef struct packed {
    logic                      wr_en;
    logic [IDX_W-1:0]          wr_idx;
    logic signed [COORD_W-1:0] wr_x;
    logic signed [COORD_W-1:0] wr_y;
    logic                      mark_en;
    logic [IDX_W-1:0]          mark_idx;
    logic                      clear;
    logic [CNT_W-1:0]          n;
    logic signed [COORD_W-1:0] cur_x;
    logic signed [COORD_W-1:0] cur_y;
  } cell_ctrl_t;

  function automatic logic [COORD_W-1:0] abs_diff(
    input logic signed [COORD_W-1:0] a,
    input logic signed [COORD_W-1:0] b
  );
    logic signed [COORD_W:0] d;
    logic signed [COORD_W:0] nd;
    d  = {a[COORD_W-1], a} - {b[COORD_W-1], b};
    nd = -d;
    return d[COORD_W] ? nd[COORD_W-1:0] : d[COORD_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ design/nnt_if.sv @@
// ----------------------------------------------------------------------------
// nnt_if: request channels of the nearest-neighbor tour builder
// Valid/ready channels for point requests in and tour indices out.
// ----------------------------------------------------------------------------
`default_nettype none

interface nnt_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [nnt_pkg::COORD_W-1:0]   x_coord;
  logic signed [nnt_pkg::COORD_W-1:0]   y_coord;
  logic                                 final_point;

  modport source (output valid, x_coord, y_coord, final_point, input ready);
  modport sink   (input valid, x_coord, y_coord, final_point, output ready);
endinterface

interface nnt_out_if;
  logic                        valid;
  logic                        ready;
  logic [nnt_pkg::IDX_W-1:0]   point_index;
  logic                        tour_end;

  modport source (output valid, point_index, tour_end, input ready);
  modport sink   (input valid, point_index, tour_end, output ready);
endinterface

`default_nettype wire

@@ design/nnt_cell.sv @@
// ----------------------------------------------------------------------------
// nnt_cell: one point cell of the search row
// Holds one point and its visited flag, registers its distance to the
// current point and passes the better of its own and the incoming candidate.
// ----------------------------------------------------------------------------
`default_nettype none

module nnt_cell (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic [nnt_pkg::IDX_W-1:0]  cell_idx,
  input  wire nnt_pkg::cell_ctrl_t        ctrl,
  input  wire nnt_pkg::cand_t             cand_i,
  output nnt_pkg::cand_t                  cand_o
);

  logic signed [nnt_pkg::COORD_W-1:0] x_r;
  logic signed [nnt_pkg::COORD_W-1:0] y_r;
  logic                               visited_r;
  logic [nnt_pkg::DIST_W-1:0]         dist_r;
  logic [nnt_pkg::DIST_W-1:0]         dist_nxt;
  nnt_pkg::cand_t                     cand_r;
  nnt_pkg::cand_t                     cand_nxt;
  logic                               elig;
  logic                               take;

  assign dist_nxt = {1'b0, nnt_pkg::abs_diff(x_r, ctrl.cur_x)}
                  + {1'b0, nnt_pkg::abs_diff(y_r, ctrl.cur_y)};

  // Only loaded, unvisited points compete; strict compare keeps the lower index on ties.
  assign elig = ({1'b0, cell_idx} < ctrl.n) && !visited_r;
  assign take = elig && (!cand_i.vld || (dist_r < cand_i.mdist));

  always_comb begin
    cand_nxt = cand_i;
    if (take) begin
      cand_nxt.vld   = 1'b1;
      cand_nxt.mdist = dist_r;
      cand_nxt.idx   = cell_idx;
      cand_nxt.x     = x_r;
      cand_nxt.y     = y_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.wr_en && (ctrl.wr_idx == cell_idx)) begin
      x_r <= ctrl.wr_x;
      y_r <= ctrl.wr_y;
    end
    dist_r <= dist_nxt;
    if (!rst_n) begin
      visited_r <= 1'b0;
      cand_r    <= '0;
    end else begin
      cand_r <= cand_nxt;
      if (ctrl.clear) begin
        visited_r <= 1'b0;
      end else if (ctrl.mark_en && (ctrl.mark_idx == cell_idx)) begin
        visited_r <= 1'b1;
      end
    end
  end

  assign cand_o = cand_r;

endmodule

`default_nettype wire

@@ design/nnt_row.sv @@
// ----------------------------------------------------------------------------
// nnt_row: row of point cells
// Chains the cells so the nearest candidate ripples one cell per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module nnt_row (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire nnt_pkg::cell_ctrl_t  ctrl,
  output nnt_pkg::cand_t            best
);

  nnt_pkg::cand_t chain [nnt_pkg::NUM_CELLS+1];

  assign chain[0] = '0;

  for (genvar i = 0; i < nnt_pkg::NUM_CELLS; i++) begin : g_cell
    nnt_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (nnt_pkg::IDX_W'(i)),
      .ctrl     (ctrl),
      .cand_i   (chain[i]),
      .cand_o   (chain[i+1])
    );
  end

  assign best = chain[nnt_pkg::NUM_CELLS];

endmodule

`default_nettype wire

@@ design/nearest_neighbour_tour_builder_top.sv @@
// ----------------------------------------------------------------------------
// nearest_neighbour_tour_builder_top: greedy Manhattan tour over loaded points
// Loads points into a row of cells, then emits the nearest-neighbor visit
// order starting at point 0.
// ----------------------------------------------------------------------------
// Usage:
//   in_req  : one point per request (x_coord, y_coord, final_point). Points
//             fill cells 0..31 in arrival order; requests past 32 points are
//             dropped, but a dropped final request still starts the build.
//   out_rsp : one request per tour position, point_index first 0, tour_end
//             set on the last one.
// Sequence:
//   A non-final point is taken while the block is idle. After a final
//   point the block emits index 0 once out_rsp is free; each further index
//   is one push, then a scan that registers distances in all cells and lets
//   the candidate ripple down the row. A low out_rsp.ready holds the push.
//   in_req.ready is high only while no tour is being built.
// Reset: clears the point count, visited flags and output valid flag; cell
//   coordinates are not reset.
// Stall: the output register holds its index while out_rsp.ready is low and
//   the sequencer waits; no index is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_neighbour_tour_builder_top (
  input  wire logic  clk,
  input  wire logic  rst_n,
  nnt_in_if.sink     in_req,
  nnt_out_if.source  out_rsp
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PUSH = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;

  logic [1:0]                          state_r, state_nxt;
  logic [nnt_pkg::CNT_W-1:0]           cnt_r, cnt_nxt;     // points loaded
  logic [nnt_pkg::CNT_W-1:0]           n_r, n_nxt;         // points in this tour
  logic [nnt_pkg::IDX_W-1:0]           pos_r, pos_nxt;     // tour position of pend
  logic [nnt_pkg::CNT_W-1:0]           timer_r, timer_nxt;
  logic [nnt_pkg::IDX_W-1:0]           pend_idx_r, pend_idx_nxt;
  logic signed [nnt_pkg::COORD_W-1:0]  p0x_r, p0y_r;       // copy of point 0
  logic signed [nnt_pkg::COORD_W-1:0]  cur_x_r, cur_x_nxt;
  logic signed [nnt_pkg::COORD_W-1:0]  cur_y_r, cur_y_nxt;
  logic                                out_vld_r, out_vld_nxt;
  logic [nnt_pkg::IDX_W-1:0]           out_idx_r;
  logic                                out_end_r;

  logic                 in_fire;
  logic                 has_room;
  logic                 out_free;
  logic                 push_fire;
  logic                 push_end;
  logic                 scan_done;
  nnt_pkg::cell_ctrl_t  ctrl;
  nnt_pkg::cand_t       best;

  assign in_req.ready = (state_r == ST_IDLE);
  assign in_fire      = in_req.valid && in_req.ready;
  assign has_room     = (cnt_r < nnt_pkg::CNT_W'(nnt_pkg::NUM_CELLS));
  assign out_free     = !out_vld_r || out_rsp.ready;
  assign push_fire    = (state_r == ST_PUSH) && out_free;
  assign push_end     = (({1'b0, pos_r} + nnt_pkg::CNT_W'(1)) == n_r);
  assign scan_done    = (state_r == ST_SCAN) && (timer_r == nnt_pkg::SCAN_LAST);

  // broadcast to the cell row
  always_comb begin
    ctrl          = '0;
    ctrl.wr_en    = in_fire && has_room;
    ctrl.wr_idx   = cnt_r[nnt_pkg::IDX_W-1:0];
    ctrl.wr_x     = in_req.x_coord;
    ctrl.wr_y     = in_req.y_coord;
    ctrl.n        = n_r;
    ctrl.cur_x    = cur_x_r;
    ctrl.cur_y    = cur_y_r;
    ctrl.clear    = push_fire && push_end;
    if (in_fire && in_req.final_point) begin
      ctrl.mark_en  = 1'b1;
      ctrl.mark_idx = '0;
    end else if (scan_done) begin
      ctrl.mark_en  = 1'b1;
      ctrl.mark_idx = best.idx;
    end
  end

  nnt_row u_row (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (ctrl),
    .best  (best)
  );

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    n_nxt        = n_r;
    pos_nxt      = pos_r;
    timer_nxt    = timer_r;
    pend_idx_nxt = pend_idx_r;
    cur_x_nxt    = cur_x_r;
    cur_y_nxt    = cur_y_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (has_room) begin
            cnt_nxt = cnt_r + nnt_pkg::CNT_W'(1);
          end
          if (in_req.final_point) begin
            n_nxt        = has_room ? cnt_r + nnt_pkg::CNT_W'(1) : cnt_r;
            pos_nxt      = '0;
            pend_idx_nxt = '0;
            // tour starts at point 0; it is this point if the set was empty
            cur_x_nxt    = (cnt_r == '0) ? in_req.x_coord : p0x_r;
            cur_y_nxt    = (cnt_r == '0) ? in_req.y_coord : p0y_r;
            state_nxt    = ST_PUSH;
          end
        end
      end
      ST_PUSH: begin
        if (push_fire) begin
          if (push_end) begin
            cnt_nxt   = '0;
            state_nxt = ST_IDLE;
          end else begin
            pos_nxt   = pos_r + nnt_pkg::IDX_W'(1);
            timer_nxt = '0;
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        timer_nxt = timer_r + nnt_pkg::CNT_W'(1);
        if (scan_done) begin
          pend_idx_nxt = best.idx;
          cur_x_nxt    = best.x;
          cur_y_nxt    = best.y;
          state_nxt    = ST_PUSH;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (push_fire) begin
      out_vld_nxt = 1'b1;
    end else if (out_rsp.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cnt_r     <= '0;
      n_r       <= '0;
      pos_r     <= '0;
      timer_r   <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      n_r       <= n_nxt;
      pos_r     <= pos_nxt;
      timer_r   <= timer_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_idx_r <= pend_idx_nxt;
    cur_x_r    <= cur_x_nxt;
    cur_y_r    <= cur_y_nxt;
    if (in_fire && (cnt_r == '0)) begin
      p0x_r <= in_req.x_coord;
      p0y_r <= in_req.y_coord;
    end
    if (push_fire) begin
      out_idx_r <= pend_idx_r;
      out_end_r <= push_end;
    end
  end

  assign out_rsp.valid       = out_vld_r;
  assign out_rsp.point_index = out_idx_r;
  assign out_rsp.tour_end    = out_end_r;

  // A finished scan always yields a loaded point.
  a_scan_found: assert property (@(posedge clk) disable iff (!rst_n)
    scan_done |-> (best.vld && ({1'b0, best.idx} < n_r)))
    else $error("scan ended without a valid candidate");

  // A final point starts the tour at index 0.
  a_start_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_req.final_point) |=> (state_r == ST_PUSH && pend_idx_r == '0))
    else $error("tour did not start at point 0");

  // Tour position stays inside the point set while building.
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> ({1'b0, pos_r} < n_r))
    else $error("tour position out of range");

  // Last index pushed returns the block to an empty point set.
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (push_fire && push_end) |=> (state_r == ST_IDLE && cnt_r == '0 && out_end_r))
    else $error("tour end did not reset the point set");

endmodule

`default_nettype wire

@@ test/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the nearest-neighbor tour builder
// Streams point sets into the block and plans each greedy Manhattan tour as
// the final point is taken. Every returned index is checked against the plan.
// Both channels idle at random; the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------

module tb;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 40;     // a bit longer than one index step of the block
  localparam int HOLD_CYCLES  = 400;    // long receiver hold-off
  localparam int HOLD_AT_TOUR = 8;      // arm the hold-off once this many tours are planned
  localparam int RANDOM_ITEMS = 200;

  // How a point set's coordinates are spread
  typedef enum int {
    SPREAD_FULL,    // any 16-bit value
    SPREAD_NEAR,    // -4..4, lots of equal distances
    SPREAD_CORNER,  // min, -1, 0, max only
    SPREAD_MIXED    // style picked per coordinate
  } spread_t;

  typedef struct {
    logic signed [nnt_pkg::COORD_W-1:0] x;
    logic signed [nnt_pkg::COORD_W-1:0] y;
    logic                               fin;
  } point_req_t;

  typedef struct packed {
    logic [nnt_pkg::IDX_W-1:0] index;
    logic                      last;
  } tour_step_t;

  logic clk = 1'b0;
  logic rst_n;

  nnt_in_if  in_req_if ();
  nnt_out_if out_rsp_if ();

  nearest_neighbour_tour_builder_top u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req_if),
    .out_rsp (out_rsp_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Point requests still to send, and tour indices still to come back
  point_req_t point_q[$];
  tour_step_t tour_q[$];

  // Bench copy of the point store
  logic signed [nnt_pkg::COORD_W-1:0] held_x [nnt_pkg::NUM_CELLS];
  logic signed [nnt_pkg::COORD_W-1:0] held_y [nnt_pkg::NUM_CELLS];
  int held_count   = 0;
  int tours_planned = 0;
  int fail_count   = 0;

  // --------------------------------------------------------------------------
  // Tour planner
  // --------------------------------------------------------------------------
  function automatic int taxicab(int a, int b);
    int dx;
    int dy;
    dx = int'(held_x[a]) - int'(held_x[b]);
    dy = int'(held_y[a]) - int'(held_y[b]);
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    return dx + dy;
  endfunction

  // Store one accepted point; on the final point, plan the whole tour.
  // A point past a full store is dropped, but a dropped final still builds.
  task automatic load_point_and_plan(input logic signed [nnt_pkg::COORD_W-1:0] x,
                                     input logic signed [nnt_pkg::COORD_W-1:0] y,
                                     input logic fin);
    int n;
    int here;
    int best;
    int best_d;
    int d;
    bit found;
    logic [nnt_pkg::NUM_CELLS-1:0] seen;
    tour_step_t step;
    if (held_count < nnt_pkg::NUM_CELLS) begin
      held_x[held_count] = x;
      held_y[held_count] = y;
      held_count++;
    end
    if (!fin) return;
    n    = held_count;
    here = 0;
    seen = '0;
    seen[0] = 1'b1;
    step.index = '0;
    step.last  = (n <= 1);
    tour_q = {tour_q, step};
    for (int pos = 1; pos < n; pos++) begin
      found  = 1'b0;
      best   = 0;
      best_d = 0;
      for (int i = 1; i < n; i++) begin
        if (!seen[i]) begin
          d = taxicab(here, i);
          // strict less-than keeps the lowest index on a tie
          if (!found || d < best_d) begin
            best   = i;
            best_d = d;
            found  = 1'b1;
          end
        end
      end
      seen[best] = 1'b1;
      here = best;
      step.index = nnt_pkg::IDX_W'(best);
      step.last  = (pos == n - 1);
      tour_q = {tour_q, step};
    end
    held_count = 0;
    tours_planned++;
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic queue_point(input logic signed [nnt_pkg::COORD_W-1:0] x,
                             input logic signed [nnt_pkg::COORD_W-1:0] y,
                             input logic fin);
    point_req_t p;
    p.x   = x;
    p.y   = y;
    p.fin = fin;
    point_q = {point_q, p};
  endtask

  function automatic logic signed [nnt_pkg::COORD_W-1:0] pick_coord(spread_t spread);
    logic signed [nnt_pkg::COORD_W-1:0] c;
    spread_t s;
    s = (spread == SPREAD_MIXED) ? spread_t'($urandom_range(0, 2)) : spread;
    case (s)
      SPREAD_NEAR: c = nnt_pkg::COORD_W'($signed($urandom_range(0, 8)) - 4);
      SPREAD_CORNER: begin
        case ($urandom_range(0, 3))
          0:       c = 16'sh8000;
          1:       c = -16'sd1;
          2:       c = 16'sd0;
          default: c = 16'sh7fff;
        endcase
      end
      default: c = nnt_pkg::COORD_W'($urandom);
    endcase
    return c;
  endfunction

  // n points, final flag on the last; past 32 points the tail is dropped
  task automatic queue_point_set(input int n, input spread_t spread);
    for (int i = 0; i < n; i++)
      queue_point(pick_coord(spread), pick_coord(spread), i == n - 1);
  endtask

  // --------------------------------------------------------------------------
  // Driver: offers queued point requests, idles between requests at random
  // while tx_idle_on is set, and plans each tour as it is accepted.
  // --------------------------------------------------------------------------
  int tx_gap       = 0;
  bit tx_idle_on   = 1'b1;
  int points_taken = 0;

  task automatic offer_next();
    point_req_t p;
    p = point_q.pop_front();
    in_req_if.valid       <= 1'b1;
    in_req_if.x_coord     <= p.x;
    in_req_if.y_coord     <= p.y;
    in_req_if.final_point <= p.fin;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_req_if.valid <= 1'b0;
      tx_gap = 0;
    end else if (in_req_if.valid && in_req_if.ready) begin
      load_point_and_plan(in_req_if.x_coord, in_req_if.y_coord,
                          in_req_if.final_point);
      points_taken++;
      if (points_taken % 40 == 0) tx_idle_on = ($urandom_range(0, 2) != 0);
      tx_gap = tx_idle_on ? $urandom_range(0, 5) : 0;
      // keep valid high straight into the next request when there is no gap
      if (tx_gap == 0 && point_q.size() != 0) offer_next();
      else in_req_if.valid <= 1'b0;
    end else if (!in_req_if.valid) begin
      if (tx_gap != 0) tx_gap--;
      else if (point_q.size() != 0) offer_next();
    end
  end

  // --------------------------------------------------------------------------
  // Long hold-off: once enough tours are planned the receiver stops for
  // HOLD_CYCLES while the driver keeps offering, so the block backs up and
  // drops in_req.ready.
  // --------------------------------------------------------------------------
  int hold_left  = 0;
  bit hold_fired = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left  <= 0;
      hold_fired <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_fired && tours_planned >= HOLD_AT_TOUR) begin
      hold_left  <= HOLD_CYCLES;
      hold_fired <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: checks each returned index against the oldest planned one
  // --------------------------------------------------------------------------
  int rx_gap       = 0;
  bit rx_idle_on   = 1'b1;
  int results_seen = 0;

  always @(posedge clk) begin
    tour_step_t want;
    if (!rst_n) begin
      out_rsp_if.ready <= 1'b0;
      rx_gap = 0;
    end else begin
      if (out_rsp_if.valid && out_rsp_if.ready) begin
        if (tour_q.size() == 0) begin
          $display("%0t: unplanned index, expected none, actual index %0d end %0b",
                   $time, out_rsp_if.point_index, out_rsp_if.tour_end);
          fail_count++;
        end else begin
          want = tour_q.pop_front();
          if (out_rsp_if.point_index !== want.index) begin
            $display("%0t: point_index expected %0d actual %0d",
                     $time, want.index, out_rsp_if.point_index);
            fail_count++;
          end
          if (out_rsp_if.tour_end !== want.last) begin
            $display("%0t: tour_end expected %0b actual %0b",
                     $time, want.last, out_rsp_if.tour_end);
            fail_count++;
          end
        end
        results_seen++;
        if (results_seen % 40 == 0) rx_idle_on = ($urandom_range(0, 2) != 0);
        rx_gap = rx_idle_on ? $urandom_range(0, 5) : 0;
      end else if (rx_gap != 0) begin
        rx_gap--;
      end
      out_rsp_if.ready <= (rx_gap == 0) && (hold_left == 0);
    end
  end

  // --------------------------------------------------------------------------
  // Timeout
  // --------------------------------------------------------------------------
  int cycles = 0;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin
    int random_items;
    int set_no;
    int n;
    rst_n                 = 1'b0;
    in_req_if.valid       = 1'b0;
    in_req_if.x_coord     = '0;
    in_req_if.y_coord     = '0;
    in_req_if.final_point = 1'b0;
    out_rsp_if.ready      = 1'b0;

    // Single point set at opposite corners: tour is just index 0, ended
    queue_point(16'sh7fff, 16'sh8000, 1'b1);
    // Four corners: widest distances, and a tie between the two side corners
    queue_point(16'sh8000, 16'sh8000, 1'b0);
    queue_point(16'sh7fff, 16'sh7fff, 1'b0);
    queue_point(16'sh8000, 16'sh7fff, 1'b0);
    queue_point(16'sh7fff, 16'sh8000, 1'b1);
    // Ring around the origin: some steps are ties broken by lowest index
    queue_point(16'sd0, 16'sd0, 1'b0);
    queue_point(16'sd1, 16'sd1, 1'b0);
    queue_point(16'sd1, 16'sd0, 1'b0);
    queue_point(16'sd0, 16'sd1, 1'b0);
    queue_point(-16'sd1, 16'sd0, 1'b0);
    queue_point(16'sd0, -16'sd1, 1'b1);
    // Coincident points: zero distances
    queue_point(16'sd5, -16'sd5, 1'b0);
    queue_point(16'sd5, -16'sd5, 1'b0);
    queue_point(16'sd5, -16'sd5, 1'b1);
    // Two-point set with all-ones coordinates
    queue_point(16'sd0, 16'sd0, 1'b0);
    queue_point(-16'sd1, -16'sd1, 1'b1);

    // Random sets, mostly small; one overflows the store so the final point
    // is dropped, one fills it exactly, and a few more big ones at random.
    random_items = 0;
    set_no       = 0;
    while (random_items < RANDOM_ITEMS) begin
      if (set_no == 2) n = nnt_pkg::NUM_CELLS + 1;
      else if (set_no == 9) n = nnt_pkg::NUM_CELLS;
      else if ($urandom_range(0, 24) == 0)
        n = $urandom_range(nnt_pkg::NUM_CELLS, nnt_pkg::NUM_CELLS + 3);
      else n = $urandom_range(1, 8);
      queue_point_set(n, spread_t'($urandom_range(0, 3)));
      random_items += n;
      set_no++;
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // sample between edges so the driver's and monitor's updates have landed
    while (point_q.size() != 0 || in_req_if.valid || tour_q.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
